// File: design/sct_pkg.sv
// Shared types and constants of the cooperative task scheduler.
// Used by the slot cell, the divide-by-ten unit and the top level.
`default_nettype none

package sct_pkg;

  // Request opcodes
  localparam logic [1:0] OP_ADD  = 2'd0;
  localparam logic [1:0] OP_TICK = 2'd1;
  localparam logic [1:0] OP_DISP = 2'd2;
  localparam logic [1:0] OP_DEL  = 2'd3;

  // Result kinds
  localparam logic [1:0] KIND_ADD  = 2'd0;
  localparam logic [1:0] KIND_RUN  = 2'd1;
  localparam logic [1:0] KIND_DEL  = 2'd2;
  localparam logic [1:0] KIND_NONE = 2'd3;

  localparam int TASK_W     = 8;
  localparam int MS_W       = 32;
  localparam int HALF_W     = MS_W / 2;
  localparam int TICK_W     = 29;
  localparam int TICK_DIV   = 10;
  // x / 10 == (x * ceil(2^35 / 10)) >> 35 for every 32-bit x
  localparam logic [MS_W-1:0] DIV10_RECIP = 32'hCCCC_CCCD;
  localparam int DIV10_SHIFT = 35;
  localparam int PEND_W     = 8;
  localparam logic [PEND_W-1:0] PEND_MAX = 8'hFF;
  localparam int RESULT_CAP = 8;
  localparam int RES_CNT_W  = $clog2(RESULT_CAP + 1);

  typedef struct packed {
    logic              used;
    logic [TASK_W-1:0] task_id;
    logic [TICK_W-1:0] dly;
    logic [TICK_W-1:0] per;
    logic [PEND_W-1:0] pend;
  } sct_slot_t;

  // Per-cell command from the sequencer
  typedef struct packed {
    logic tick;
    logic load;
    logic take_next;
    logic dec;
  } sct_cmd_t;

endpackage

`default_nettype wire

// File: design/sct_div10.sv
// Divide-by-ten by reciprocal multiplication, two pipeline stages after go.
// Depends on sct_pkg for widths, the reciprocal and the shift.
`default_nettype none

module sct_div10
  import sct_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              go,
  input  wire logic [MS_W-1:0]   dividend,
  output logic                   done,
  output logic [TICK_W-1:0]      quotient
);

  localparam int PP_W = MS_W + HALF_W;

  logic [MS_W-1:0]   x_r, x_nxt;
  logic [PP_W-1:0]   lo_r, lo_nxt;
  logic [PP_W-1:0]   hi_r, hi_nxt;
  logic [TICK_W-1:0] q_r, q_nxt;
  logic              s1_r, s2_r, done_r;
  logic [2*MS_W-1:0] prod;

  assign x_nxt  = go ? dividend : x_r;
  // split the reciprocal in halves: two narrow partial products
  assign lo_nxt = {{HALF_W{1'b0}}, x_r} * {{MS_W{1'b0}}, DIV10_RECIP[HALF_W-1:0]};
  assign hi_nxt = {{HALF_W{1'b0}}, x_r} * {{MS_W{1'b0}}, DIV10_RECIP[MS_W-1:HALF_W]};
  assign prod   = {{(2*MS_W-PP_W){1'b0}}, lo_r} + {hi_r, {HALF_W{1'b0}}};
  assign q_nxt  = prod[DIV10_SHIFT +: TICK_W];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_r   <= 1'b0;
      s2_r   <= 1'b0;
      done_r <= 1'b0;
    end else begin
      s1_r   <= go;
      s2_r   <= s1_r;
      done_r <= s2_r;
    end
  end

  always_ff @(posedge clk) begin
    x_r  <= x_nxt;
    lo_r <= lo_nxt;
    hi_r <= hi_nxt;
    q_r  <= q_nxt;
  end

  assign done     = done_r;
  assign quotient = q_r;

endmodule

`default_nettype wire

// File: design/sct_cell.sv
// One task slot of the scheduler chain: ticks on its own, loads, decrements
// its pending count, or takes over its right-hand neighbour on a removal.
// Depends on sct_pkg for the slot and command types.
`default_nettype none

module sct_cell
  import sct_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  sct_cmd_t   cmd_i,
  input  sct_slot_t  new_i,
  input  sct_slot_t  next_i,
  output sct_slot_t  slot_o
);

  logic              used_r, used_nxt;
  logic [TASK_W-1:0] task_r, task_nxt;
  logic [TICK_W-1:0] dly_r, dly_nxt;
  logic [TICK_W-1:0] per_r, per_nxt;
  logic [PEND_W-1:0] pend_r, pend_nxt;

  always_comb begin
    used_nxt = used_r;
    task_nxt = task_r;
    dly_nxt  = dly_r;
    per_nxt  = per_r;
    pend_nxt = pend_r;
    if (cmd_i.take_next) begin
      used_nxt = next_i.used;
      task_nxt = next_i.task_id;
      dly_nxt  = next_i.dly;
      per_nxt  = next_i.per;
      pend_nxt = next_i.pend;
    end else if (cmd_i.load) begin
      used_nxt = new_i.used;
      task_nxt = new_i.task_id;
      dly_nxt  = new_i.dly;
      per_nxt  = new_i.per;
      pend_nxt = new_i.pend;
    end else if (cmd_i.dec) begin
      pend_nxt = pend_r - PEND_W'(1);
    end else if (cmd_i.tick && used_r) begin
      if (dly_r != '0) begin
        dly_nxt = dly_r - TICK_W'(1);
      end else begin
        // due: add a pending run (saturating) and reload
        if (pend_r != PEND_MAX) pend_nxt = pend_r + PEND_W'(1);
        dly_nxt = per_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r <= 1'b0;
    end else begin
      used_r <= used_nxt;
    end
  end

  always_ff @(posedge clk) begin
    task_r <= task_nxt;
    dly_r  <= dly_nxt;
    per_r  <= per_nxt;
    pend_r <= pend_nxt;
  end

  assign slot_o = '{used: used_r, task_id: task_r, dly: dly_r, per: per_r, pend: pend_r};

endmodule

`default_nettype wire

// File: design/cooperative_task_scheduler.sv
// Cooperative task scheduler: a chain of MAX_TASKS slot cells in insertion
// order. A tick gives no result. An add holds busy while the two-stage
// reciprocal multiply turns milliseconds into ticks, and its reply is
// strobed in the cycle busy drops; an add to a full table replies without
// going busy. Dispatch and delete walk the chain one slot per cycle through
// a shared head compare. Results appear one per cycle on out_strobe and
// cannot be held off; a dispatch may leave gaps between them.
// Depends on sct_pkg, sct_cell and sct_div10.
`default_nettype none

module cooperative_task_scheduler
  import sct_pkg::*;
#(
  parameter int MAX_TASKS = 8,
  parameter int ID_BITS   = 8
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  output logic                   busy,
  input  wire logic [1:0]        in_opcode,
  input  wire logic [TASK_W-1:0] in_task_id,
  input  wire logic [MS_W-1:0]   in_delay_ms,
  input  wire logic [MS_W-1:0]   in_period_ms,
  output logic                   out_strobe,
  output logic [1:0]             out_kind,
  output logic [TASK_W-1:0]      out_task_id_out,
  output logic                   out_ok,
  output logic                   out_last
);

  localparam int CW = $clog2(MAX_TASKS + 1);
  localparam int IW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam logic [TASK_W-1:0] IdMask =
    (ID_BITS >= TASK_W) ? {TASK_W{1'b1}} : TASK_W'((64'd1 << ID_BITS) - 64'd1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_DISP = 2'd2;
  localparam logic [1:0] ST_DEL  = 2'd3;

  logic [1:0]           state_r, state_nxt;
  logic [CW-1:0]        count_r, count_nxt;
  logic [CW-1:0]        ptr_r, ptr_nxt;
  logic [RES_CNT_W-1:0] nres_r, nres_nxt;
  logic                 hold_v_r, hold_v_nxt;
  logic [TASK_W-1:0]    hold_id_r, hold_id_nxt;
  logic [TASK_W-1:0]    id_r, id_nxt;

  logic                 strobe_r, strobe_nxt;
  logic [1:0]           kind_r, kind_nxt;
  logic [TASK_W-1:0]    oid_r, oid_nxt;
  logic                 ok_r, ok_nxt;
  logic                 last_r, last_nxt;

  logic                 accept;
  logic [TASK_W-1:0]    in_id;
  logic                 tick_en, load_en, dec_en, rm_en, div_go;
  logic                 div_d_done, div_p_done;
  logic [TICK_W-1:0]    q_dly, q_per;
  logic                 in_range;

  sct_slot_t            slots [MAX_TASKS];
  sct_cmd_t             cmds  [MAX_TASKS];
  sct_slot_t            new_slot;
  sct_slot_t            cur;
  logic [MAX_TASKS-1:0] used_vec;

  assign busy     = (state_r != ST_IDLE);
  assign accept   = start && !busy;
  assign in_id    = in_task_id & IdMask;
  assign in_range = ptr_r < count_r;
  assign cur      = slots[ptr_r[IW-1:0]];
  assign new_slot = '{used: 1'b1, task_id: id_r, dly: q_dly, per: q_per, pend: '0};

  sct_div10 u_div_dly (
    .clk      (clk),
    .rst_n    (rst_n),
    .go       (div_go),
    .dividend (in_delay_ms),
    .done     (div_d_done),
    .quotient (q_dly)
  );

  sct_div10 u_div_per (
    .clk      (clk),
    .rst_n    (rst_n),
    .go       (div_go),
    .dividend (in_period_ms),
    .done     (div_p_done),
    .quotient (q_per)
  );

  for (genvar j = 0; j < MAX_TASKS; j++) begin : g_cell
    sct_slot_t next_slot;

    if (j < MAX_TASKS - 1) begin : g_mid
      assign next_slot = slots[j+1];
    end else begin : g_end
      assign next_slot = '0;
    end

    assign cmds[j].tick      = tick_en;
    assign cmds[j].load      = load_en && (count_r == CW'(j));
    assign cmds[j].take_next = rm_en && (ptr_r <= CW'(j));
    assign cmds[j].dec       = dec_en && (ptr_r == CW'(j));
    assign used_vec[j]       = slots[j].used;

    sct_cell u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .cmd_i  (cmds[j]),
      .new_i  (new_slot),
      .next_i (next_slot),
      .slot_o (slots[j])
    );
  end

  always_comb begin
    state_nxt   = state_r;
    count_nxt   = count_r;
    ptr_nxt     = ptr_r;
    nres_nxt    = nres_r;
    hold_v_nxt  = hold_v_r;
    hold_id_nxt = hold_id_r;
    id_nxt      = id_r;
    strobe_nxt  = 1'b0;
    kind_nxt    = kind_r;
    oid_nxt     = oid_r;
    ok_nxt      = ok_r;
    last_nxt    = last_r;
    tick_en     = 1'b0;
    load_en     = 1'b0;
    dec_en      = 1'b0;
    rm_en       = 1'b0;
    div_go      = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          case (in_opcode)
            OP_ADD: begin
              if (count_r == CW'(MAX_TASKS)) begin
                strobe_nxt = 1'b1;
                kind_nxt   = KIND_ADD;
                oid_nxt    = in_id;
                ok_nxt     = 1'b0;
                last_nxt   = 1'b1;
              end else begin
                div_go    = 1'b1;
                id_nxt    = in_id;
                state_nxt = ST_DIV;
              end
            end
            OP_TICK: tick_en = 1'b1;
            OP_DISP: begin
              ptr_nxt    = '0;
              nres_nxt   = '0;
              hold_v_nxt = 1'b0;
              state_nxt  = ST_DISP;
            end
            OP_DEL: begin
              ptr_nxt   = '0;
              id_nxt    = in_id;
              state_nxt = ST_DEL;
            end
            default: state_nxt = ST_IDLE;
          endcase
        end
      end

      ST_DIV: begin
        if (div_d_done && div_p_done) begin
          load_en    = 1'b1;
          count_nxt  = count_r + CW'(1);
          strobe_nxt = 1'b1;
          kind_nxt   = KIND_ADD;
          oid_nxt    = id_r;
          ok_nxt     = 1'b1;
          last_nxt   = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end

      ST_DISP: begin
        if (!in_range || nres_r == RES_CNT_W'(RESULT_CAP)) begin
          // flush the held run as the final result, or report nothing ready
          strobe_nxt = 1'b1;
          kind_nxt   = hold_v_r ? KIND_RUN : KIND_NONE;
          oid_nxt    = hold_v_r ? hold_id_r : '0;
          ok_nxt     = 1'b0;
          last_nxt   = 1'b1;
          state_nxt  = ST_IDLE;
        end else if (cur.pend != '0) begin
          // hold this run back one step so the last one can be marked
          if (hold_v_r) begin
            strobe_nxt = 1'b1;
            kind_nxt   = KIND_RUN;
            oid_nxt    = hold_id_r;
            ok_nxt     = 1'b0;
            last_nxt   = 1'b0;
          end
          hold_v_nxt  = 1'b1;
          hold_id_nxt = cur.task_id;
          nres_nxt    = nres_r + RES_CNT_W'(1);
          if (cur.per == '0) begin
            rm_en     = 1'b1;
            count_nxt = count_r - CW'(1);
          end else begin
            dec_en  = 1'b1;
            ptr_nxt = ptr_r + CW'(1);
          end
        end else begin
          ptr_nxt = ptr_r + CW'(1);
        end
      end

      ST_DEL: begin
        if (!in_range) begin
          strobe_nxt = 1'b1;
          kind_nxt   = KIND_DEL;
          oid_nxt    = id_r;
          ok_nxt     = 1'b0;
          last_nxt   = 1'b1;
          state_nxt  = ST_IDLE;
        end else if (cur.task_id == id_r) begin
          rm_en      = 1'b1;
          count_nxt  = count_r - CW'(1);
          strobe_nxt = 1'b1;
          kind_nxt   = KIND_DEL;
          oid_nxt    = id_r;
          ok_nxt     = 1'b1;
          last_nxt   = 1'b1;
          state_nxt  = ST_IDLE;
        end else begin
          ptr_nxt = ptr_r + CW'(1);
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      count_r  <= '0;
      hold_v_r <= 1'b0;
      strobe_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      count_r  <= count_nxt;
      hold_v_r <= hold_v_nxt;
      strobe_r <= strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ptr_r     <= ptr_nxt;
    nres_r    <= nres_nxt;
    hold_id_r <= hold_id_nxt;
    id_r      <= id_nxt;
    kind_r    <= kind_nxt;
    oid_r     <= oid_nxt;
    ok_r      <= ok_nxt;
    last_r    <= last_nxt;
  end

  assign out_strobe      = strobe_r;
  assign out_kind        = kind_r;
  assign out_task_id_out = oid_r;
  assign out_ok          = ok_r;
  assign out_last        = last_r;

  // Every request that occupies the block ends with its final result.
  a_fin_last: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && $fell(busy) |-> out_strobe && out_last)
    else $error("busy dropped without a final result");

  // The number of occupied cells matches the task count.
  a_used_count: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(used_vec) == count_r)
    else $error("occupied cells disagree with task count");

  a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(MAX_TASKS))
    else $error("task count beyond table size");

  a_none_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_kind == KIND_NONE |-> out_last && !out_ok)
    else $error("nothing-ready result not final");

endmodule

`default_nettype wire

// File: test/testbench.sv
`timescale 1ns / 100ps
// Self-checking bench for the cooperative task scheduler: a task table tracker
// predicts every reply from the accepted requests and checks each strobed result.
// Depends on sct_pkg and the cooperative_task_scheduler top level.

import sct_pkg::*;

typedef struct packed {
  logic [1:0]        kind;
  logic [TASK_W-1:0] task_id;
  logic              ok;
  logic              last;
} sched_reply_t;

class sched_tracker #(int SLOTS = 8);
  bit [TASK_W-1:0] slot_id   [SLOTS];
  bit [TICK_W-1:0] slot_dly  [SLOTS];
  bit [TICK_W-1:0] slot_per  [SLOTS];
  bit [PEND_W-1:0] slot_pend [SLOTS];
  int              n_tasks;
  sched_reply_t    replies_due[$];
  int              errors;

  // Close the gap left by a removed slot, keeping insertion order
  function void drop_slot(int idx);
    for (int j = idx; j + 1 < n_tasks; j++) begin
      slot_id[j]   = slot_id[j+1];
      slot_dly[j]  = slot_dly[j+1];
      slot_per[j]  = slot_per[j+1];
      slot_pend[j] = slot_pend[j+1];
    end
    n_tasks--;
  endfunction

  function void due(logic [1:0] kind, logic [TASK_W-1:0] id, logic ok);
    replies_due.push_back('{kind: kind, task_id: id, ok: ok, last: 1'b0});
  endfunction

  function void take_request(logic [1:0] op, logic [TASK_W-1:0] id,
                             logic [MS_W-1:0] dly, logic [MS_W-1:0] per);
    int i;
    int n;
    bit found;
    n = 0;
    case (op)
      OP_ADD: begin
        if (n_tasks < SLOTS) begin
          slot_id[n_tasks]   = id;
          slot_dly[n_tasks]  = TICK_W'(dly / TICK_DIV);
          slot_per[n_tasks]  = TICK_W'(per / TICK_DIV);
          slot_pend[n_tasks] = '0;
          n_tasks++;
          due(KIND_ADD, id, 1'b1);
        end else begin
          due(KIND_ADD, id, 1'b0);
        end
        n = 1;
      end
      OP_TICK: begin
        for (i = 0; i < n_tasks; i++) begin
          if (slot_dly[i] != 0) begin
            slot_dly[i]--;
          end else begin
            if (slot_pend[i] != PEND_MAX) slot_pend[i]++;
            slot_dly[i] = slot_per[i];
          end
        end
      end
      OP_DISP: begin
        i = 0;
        while (i < n_tasks && n < RESULT_CAP) begin
          if (slot_pend[i] != 0) begin
            slot_pend[i]--;
            due(KIND_RUN, slot_id[i], 1'b0);
            n++;
            // one-shot: the next slot slides into this index
            if (slot_per[i] == 0) begin
              drop_slot(i);
              continue;
            end
          end
          i++;
        end
        if (n == 0) begin
          due(KIND_NONE, '0, 1'b0);
          n = 1;
        end
      end
      default: begin
        found = 1'b0;
        for (i = 0; i < n_tasks; i++) begin
          if (slot_id[i] == id) begin
            drop_slot(i);
            found = 1'b1;
            break;
          end
        end
        due(KIND_DEL, id, found);
        n = 1;
      end
    endcase
    if (n != 0) replies_due[replies_due.size()-1].last = 1'b1;
  endfunction

  function void flag(string what, logic [7:0] want, logic [7:0] got);
    errors++;
    if (errors <= 40)
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
  endfunction

  function void check_reply(sched_reply_t got);
    sched_reply_t want;
    if (replies_due.size() == 0) begin
      errors++;
      if (errors <= 40)
        $display("%0t: result with nothing expected, actual kind %0h id %0h ok %0h last %0h",
                 $time, got.kind, got.task_id, got.ok, got.last);
      return;
    end
    want = replies_due.pop_front();
    if (got.kind !== want.kind)       flag("kind", want.kind, got.kind);
    if (got.task_id !== want.task_id) flag("task_id_out", want.task_id, got.task_id);
    if (got.ok !== want.ok)           flag("ok", want.ok, got.ok);
    if (got.last !== want.last)       flag("last", want.last, got.last);
  endfunction
endclass

module testbench;
  localparam int SLOTS          = 8;
  localparam int WATCHDOG_LIMIT = 5000;

  logic              clk          = 1'b0;
  logic              rst_n        = 1'b0;
  logic              start        = 1'b0;
  logic [1:0]        in_opcode    = OP_TICK;
  logic [TASK_W-1:0] in_task_id   = '0;
  logic [MS_W-1:0]   in_delay_ms  = '0;
  logic [MS_W-1:0]   in_period_ms = '0;
  wire               busy;
  wire               out_strobe;
  wire [1:0]         out_kind;
  wire [TASK_W-1:0]  out_task_id_out;
  wire               out_ok;
  wire               out_last;

  sched_tracker #(SLOTS) tracker = new;
  bit steady = 1'b0;
  int quiet_cycles = 0;

  cooperative_task_scheduler #(.MAX_TASKS(SLOTS), .ID_BITS(8)) u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_opcode       (in_opcode),
    .in_task_id      (in_task_id),
    .in_delay_ms     (in_delay_ms),
    .in_period_ms    (in_period_ms),
    .out_strobe      (out_strobe),
    .out_kind        (out_kind),
    .out_task_id_out (out_task_id_out),
    .out_ok          (out_ok),
    .out_last        (out_last)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Note accepted requests before checking results of the same edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (start && !busy)
        tracker.take_request(in_opcode, in_task_id, in_delay_ms, in_period_ms);
      if (out_strobe !== 1'b0)
        tracker.check_reply({out_kind, out_task_id_out, out_ok, out_last});
      if ((start && !busy) || out_strobe === 1'b1) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
        $display("== FAIL ==");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  task automatic issue(logic [1:0] op, logic [TASK_W-1:0] id,
                       logic [MS_W-1:0] dly, logic [MS_W-1:0] per);
    while (!steady && $urandom_range(99) < 26) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start        <= 1'b1;
    in_opcode    <= op;
    in_task_id   <= id;
    in_delay_ms  <= dly;
    in_period_ms <= per;
    do @(posedge clk); while (!(start && !busy));
  endtask

  // Hold requests back until every reply has come, then let the block settle
  task automatic settle();
    start <= 1'b0;
    while (tracker.replies_due.size() != 0) @(posedge clk);
    repeat (SLOTS + 40) @(posedge clk);
  endtask

  function automatic logic [MS_W-1:0] pick_ms();
    case ($urandom_range(9))
      0:       return $urandom;
      1:       return '0;
      default: return $urandom_range(0, 49);
    endcase
  endfunction

  initial begin
    int r;
    logic [TASK_W-1:0] id;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // empty table: delete, dispatch and tick
    issue(OP_DEL, 8'h2A, '0, '0);
    issue(OP_DISP, '0, '0, '0);
    issue(OP_TICK, '0, '0, '0);
    // field extremes, sub-tick rounding and a one-shot sharing an id
    issue(OP_ADD, 8'h00, '0, '0);
    issue(OP_ADD, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    issue(OP_ADD, 8'h11, 32'd9, 32'd19);
    issue(OP_ADD, 8'h11, 32'd0, 32'd0);
    for (int k = 0; k < 4; k++) issue(OP_ADD, TASK_W'(8'h40 + k), '0, 32'd20);
    issue(OP_ADD, 8'h99, 32'd30, 32'd30);
    // table full
    issue(OP_ADD, 8'h5C, 32'd10, 32'd10);
    issue(OP_TICK, '0, '0, '0);
    // full dispatch, then nothing ready
    issue(OP_DISP, '0, '0, '0);
    issue(OP_DISP, '0, '0, '0);
    issue(OP_ADD, 8'h11, 32'd5000, 32'd0);
    issue(OP_DEL, 8'h11, '0, '0);
    issue(OP_DEL, 8'h77, '0, '0);
    // empty the table, the final delete hitting the only task
    issue(OP_DEL, 8'hFF, '0, '0);
    for (int k = 0; k < 4; k++) issue(OP_DEL, TASK_W'(8'h40 + k), '0, '0);
    issue(OP_DEL, 8'h99, '0, '0);
    issue(OP_DEL, 8'h11, '0, '0);
    settle();

    for (int k = 0; k < 194; k++) begin
      steady = (k >= 80 && k < 130);
      if (k == 50 || k == 130) settle();
      id = ($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 5));
      r = $urandom_range(99);
      if (r < 22)      issue(OP_ADD, id, pick_ms(), pick_ms());
      else if (r < 60) issue(OP_TICK, 8'($urandom), $urandom, $urandom);
      else if (r < 80) issue(OP_DISP, 8'($urandom), $urandom, $urandom);
      else             issue(OP_DEL, id, $urandom, $urandom);
    end
    settle();

    if (tracker.errors == 0 && tracker.replies_due.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule

// File: sim.f
design/sct_pkg.sv
design/sct_div10.sv
design/sct_cell.sv
design/cooperative_task_scheduler.sv
test/testbench.sv
